### sv/buvm_pkg.sv
// shared types, widths and constants of the battery under-voltage monitor
// no dependencies
`default_nettype none

package buvm_pkg;

	// field and register widths
	localparam int ADC_W       = 12;
	localparam int MV_W        = 14;
	localparam int DEB_W       = 4;
	localparam int CFG_W       = 14;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	// divider unit: the running sum sits left aligned in a product-wide dividend,
	// divisor is the fill count
	localparam int PROD_W = ADC_W + MV_W;
	localparam int DVR_W  = 12;
	localparam int CNT_W  = $clog2(PROD_W + 1);

	localparam logic [DVR_W-1:0] FULL_CODE  = 12'd4095;
	localparam logic [DEB_W-1:0] STREAK_MAX = 4'd15;

	// scaling by 1/4095 for a product below 2^26: multiply by 2^26 + 2^14 + 5
	// (2^38 / 4095 rounded up) and keep the bits from 38 up
	localparam int RCP_SHIFT = PROD_W + ADC_W;

	// default ring depth
	localparam int AVG_DEPTH_DEF = 8;

	// register reset values
	localparam logic [MV_W-1:0]  FULL_SCALE_RST = 14'd13300;
	localparam logic [MV_W-1:0]  TRIP_RST       = 14'd9000;
	localparam logic [MV_W-1:0]  RECOVER_RST    = 14'd9600;
	localparam logic [DEB_W-1:0] DEBOUNCE_RST   = 4'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIP       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVER    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_AVG_GO,
		ST_AVG_RUN,
		ST_MUL,
		ST_SCALE,
		ST_MV,
		ST_FINISH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic update;
		logic div_go;
		logic cap_avg;
		logic mul;
		logic scale;
		logic cap_mv;
		logic finish;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_free;
	} ctrl_stat_t;

endpackage

`default_nettype wire

### sv/buvm_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module buvm_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/buvm_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on buvm_pkg
`default_nettype none

module buvm_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [buvm_pkg::PROD_W-1:0]  dividend,
	input  wire logic [buvm_pkg::DVR_W-1:0]   divisor,
	input  wire logic [buvm_pkg::CNT_W-1:0]   nbits,
	output logic      [buvm_pkg::PROD_W-1:0]  quotient,
	output logic                              done
);

	logic [buvm_pkg::PROD_W-1:0] quot_q;
	logic [buvm_pkg::DVR_W-1:0]  rem_q;
	logic [buvm_pkg::DVR_W-1:0]  dvr_q;
	logic [buvm_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [buvm_pkg::DVR_W:0]    trial;
	logic [buvm_pkg::DVR_W:0]    diff;
	logic                        ge;

	// dividend is left aligned so only nbits steps are needed
	assign trial = {rem_q, quot_q[buvm_pkg::PROD_W-1]};
	assign diff  = trial - {1'b0, dvr_q};
	assign ge    = (trial >= {1'b0, dvr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == buvm_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvr_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[buvm_pkg::PROD_W-2:0], ge};
			rem_q  <= ge ? diff[buvm_pkg::DVR_W-1:0] : trial[buvm_pkg::DVR_W-1:0];
		end
	end

	assign quotient = quot_q;
	assign done     = done_q;

endmodule

`default_nettype wire

### sv/buvm_datapath.sv
// sample ring, running sum, scaling, hysteresis and output register
// depends on buvm_pkg, buvm_ram, buvm_div
`default_nettype none

module buvm_datapath #(
	parameter int AVG_DEPTH = buvm_pkg::AVG_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire buvm_pkg::ctrl_cmd_t                cmd,
	output buvm_pkg::ctrl_stat_t                    stat,
	input  wire logic [buvm_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [buvm_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [buvm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [buvm_pkg::CFG_W-1:0]         cfg_data
);

	localparam int IDX_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int FILL_W = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W  = buvm_pkg::ADC_W + $clog2(AVG_DEPTH);

	localparam int ADC_W = buvm_pkg::ADC_W;
	localparam int MV_W  = buvm_pkg::MV_W;
	localparam int DEB_W = buvm_pkg::DEB_W;

	// reciprocal scaling: product * 4097 and product * 5, then (hi << 14) + lo
	localparam int HI_W  = buvm_pkg::PROD_W + ADC_W;
	localparam int LO_W  = buvm_pkg::PROD_W + 3;
	localparam int RCP_W = HI_W + MV_W + 1;

	// configuration
	logic [MV_W-1:0]  fs_q, trip_q, recover_q;
	logic [DEB_W-1:0] deb_q;

	// averaging state
	logic [ADC_W-1:0]  sample_q;
	logic [SUM_W-1:0]  sum_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  wr_idx_q;
	logic              full;

	// scaling
	logic [ADC_W-1:0]            avg_q;
	logic [buvm_pkg::PROD_W-1:0] prod_q;
	logic [HI_W-1:0]             scl_hi_q;
	logic [LO_W-1:0]             scl_lo_q;
	logic [RCP_W-1:0]            scl_sum;
	logic [MV_W-1:0]             mv_q;

	// hysteresis
	logic             low_q;
	logic [DEB_W-1:0] streak_q;

	// output register
	logic                               m_valid_q;
	logic [buvm_pkg::OUT_TDATA_W-1:0]   m_data_q;

	logic [ADC_W-1:0]             ring_rdata;
	logic [IDX_W-1:0]             ring_waddr;
	logic [buvm_pkg::PROD_W-1:0]  div_dividend;
	logic [buvm_pkg::DVR_W-1:0]   div_divisor;
	logic [buvm_pkg::CNT_W-1:0]   div_nbits;
	logic [buvm_pkg::PROD_W-1:0]  div_quot;
	logic                         div_done;
	logic [MV_W-1:0]              mv;
	logic                         oob;
	logic [DEB_W-1:0]             streak_inc;
	logic                         flip;

	assign full       = (fill_q == FILL_W'(AVG_DEPTH));
	assign ring_waddr = full ? wr_idx_q : fill_q[IDX_W-1:0];

	buvm_ram #(
		.WIDTH (ADC_W),
		.DEPTH (AVG_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (ring_waddr),
		.wdata (sample_q),
		.re    (cmd.load_in),
		.raddr (wr_idx_q),
		.rdata (ring_rdata)
	);

	// divider operands: sum / fill
	assign div_dividend = {sum_q, {(buvm_pkg::PROD_W - SUM_W){1'b0}}};
	assign div_divisor  = buvm_pkg::DVR_W'(fill_q);
	assign div_nbits    = buvm_pkg::CNT_W'(SUM_W);

	buvm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.nbits    (div_nbits),
		.quotient (div_quot),
		.done     (div_done)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q      <= buvm_pkg::FULL_SCALE_RST;
			trip_q    <= buvm_pkg::TRIP_RST;
			recover_q <= buvm_pkg::RECOVER_RST;
			deb_q     <= buvm_pkg::DEBOUNCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				buvm_pkg::REG_FULL_SCALE: fs_q      <= cfg_data[MV_W-1:0];
				buvm_pkg::REG_TRIP:       trip_q    <= cfg_data[MV_W-1:0];
				buvm_pkg::REG_RECOVER:    recover_q <= cfg_data[MV_W-1:0];
				buvm_pkg::REG_DEBOUNCE:   deb_q     <= cfg_data[DEB_W-1:0];
			endcase
		end
	end

	// ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			fill_q   <= '0;
			wr_idx_q <= '0;
		end else if (cmd.update) begin
			if (full) begin
				sum_q <= sum_q - SUM_W'(ring_rdata) + SUM_W'(sample_q);
				if (wr_idx_q == IDX_W'(AVG_DEPTH - 1)) begin
					wr_idx_q <= '0;
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end else begin
				sum_q  <= sum_q + SUM_W'(sample_q);
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// scaled value is (product * (2^26 + 2^14 + 5)) >> 38, exact below 2^26
	assign scl_sum = {1'b0, scl_hi_q, {MV_W{1'b0}}} + RCP_W'(scl_lo_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= s_tdata[ADC_W-1:0];
		end
		if (cmd.cap_avg) begin
			avg_q <= div_quot[ADC_W-1:0];
		end
		if (cmd.mul) begin
			prod_q <= buvm_pkg::PROD_W'(avg_q) * buvm_pkg::PROD_W'(fs_q);
		end
		if (cmd.scale) begin
			scl_hi_q <= HI_W'(prod_q) + {prod_q, {ADC_W{1'b0}}};
			scl_lo_q <= LO_W'(prod_q) + {1'b0, prod_q, 2'b00};
		end
		if (cmd.cap_mv) begin
			mv_q <= scl_sum[buvm_pkg::RCP_SHIFT +: MV_W];
		end
	end

	// hysteresis decision
	assign mv         = mv_q;
	assign oob        = low_q ? (mv > recover_q) : (mv < trip_q);
	assign streak_inc = (streak_q == buvm_pkg::STREAK_MAX) ? streak_q : streak_q + 1'b1;
	assign flip       = oob && (streak_inc >= deb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= 1'b0;
			streak_q <= '0;
		end else if (cmd.finish) begin
			if (!oob || flip) begin
				streak_q <= '0;
			end else begin
				streak_q <= streak_inc;
			end
			if (flip) begin
				low_q <= !low_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_data_q <= {
				{(buvm_pkg::OUT_TDATA_W - MV_W - 3){1'b0}},
				flip & low_q,
				flip & !low_q,
				low_q ^ flip,
				mv
			};
		end
	end

	assign m_tvalid      = m_valid_q;
	assign m_tdata       = m_data_q;
	assign stat.div_done = div_done;
	assign stat.out_free = !m_valid_q || m_tready;

endmodule

`default_nettype wire

### sv/buvm_ctrl.sv
// sequencing state machine of the monitor
// depends on buvm_pkg
`default_nettype none

module buvm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire buvm_pkg::ctrl_stat_t  stat,
	output buvm_pkg::ctrl_cmd_t        cmd
);

	buvm_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= buvm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			buvm_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = buvm_pkg::ST_UPDATE;
				end
			end
			buvm_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = buvm_pkg::ST_AVG_GO;
			end
			buvm_pkg::ST_AVG_GO: begin
				cmd.div_go = 1'b1;
				state_d    = buvm_pkg::ST_AVG_RUN;
			end
			buvm_pkg::ST_AVG_RUN: begin
				cmd.cap_avg = stat.div_done;
				if (stat.div_done) begin
					state_d = buvm_pkg::ST_MUL;
				end
			end
			buvm_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = buvm_pkg::ST_SCALE;
			end
			buvm_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = buvm_pkg::ST_MV;
			end
			buvm_pkg::ST_MV: begin
				cmd.cap_mv = 1'b1;
				state_d    = buvm_pkg::ST_FINISH;
			end
			buvm_pkg::ST_FINISH: begin
				cmd.finish = stat.out_free;
				if (stat.out_free) begin
					state_d = buvm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = buvm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/battery_undervoltage_monitor_core.sv
// top level of the battery under-voltage monitor
// depends on buvm_pkg, buvm_ctrl, buvm_datapath (and through it buvm_ram, buvm_div)
//
//  channel   direction  signals                       contents
//  s_axis    in         s_tvalid s_tready s_tdata     adc sample
//  m_axis    out        m_tvalid m_tready m_tdata     millivolts and protection flags
//  cfg       in         cfg_we cfg_index cfg_data     full scale, trip, recover, debounce
//
// most of the time from transfer to result is the serial divide of the sum by
// the fill count; the scaling by 1/4095 is a shift-and-add reciprocal, with the
// products by 4097 and by 5 registered before their sum is taken as millivolts
// the next sample is taken the cycle after the result is in the output
// register, so a new sample is never taken while the last is still in progress
// a stalled result holds the last step until the output register frees up
// reset clears the sum, fill count, index, flag, streak and output valid;
// the ring needs no clearing, its output is used only when all slots are written
`default_nettype none

module battery_undervoltage_monitor_core #(
	parameter int AVG_DEPTH = buvm_pkg::AVG_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// sample input
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [buvm_pkg::IN_TDATA_W-1:0]    s_tdata,   // [11:0] adc_sample
	// result output
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [buvm_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [13:0] battery_mv,
	                                                           // [14] under_voltage,
	                                                           // [15] entered_low,
	                                                           // [16] recovered
	// configuration writes
	input  wire logic                               cfg_we,
	input  wire logic [buvm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [buvm_pkg::CFG_W-1:0]         cfg_data
);

	// command and status between the sequencer and the datapath
	buvm_pkg::ctrl_cmd_t  cmd;
	buvm_pkg::ctrl_stat_t stat;

	// sequencer: accepts a sample only while idle, steps through the
	// ring update, averaging divide, multiply, the two scaling steps and the finish
	buvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: ring memory, running sum, serial divider, reciprocal
	// scaling, hysteresis and the output register
	buvm_datapath #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire
